@@ hdl/ssm_pkg.sv @@
package ssm_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 8;
    localparam int LEN_CFG_W = 9;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register index within the configuration space (word address).
    localparam logic [PADDR_W-3:0] REG_PATTERN_LENGTH = 1'b0;

    localparam logic [LEN_CFG_W-1:0] PATTERN_LENGTH_RESET = 9'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // Group size of the first level of the hit reduction.
    localparam int HIT_GROUP = 16;

    // Broadcast control from the top level to every cell of the chain.
    typedef struct packed {
        logic              advance;
        logic              load;
        logic              scan;
        logic              clear;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] value;
    } ssm_cell_ctrl_t;

endpackage

@@ hdl/ssm_if.sv @@
interface ssm_item_if;
    import ssm_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic              last;

    modport source (output valid, op, position, value, last, input ready);
    modport sink   (input valid, op, position, value, last, output ready);
endinterface

interface ssm_result_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

@@ hdl/ssm_cell.sv @@
module ssm_cell
    import ssm_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int          IDX_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ssm_cell_ctrl_t   ctrl,
    input  logic [IDX_W-1:0] last_idx,
    input  logic             prev_match,
    output logic             match,
    output logic             hit
);

    logic [BYTE_W-1:0] pattern_reg;
    logic              match_reg;
    logic              match_next;
    logic              hit_reg;
    logic              hit_next;
    logic              active;
    logic              is_last;

    always_comb
    begin
        active     = (INDEX <= 32'(last_idx));
        is_last    = (INDEX == 32'(last_idx));
        // Entries at or beyond the length in use are forced to zero.
        match_next = prev_match && (pattern_reg == ctrl.value) && active;
        hit_next   = ctrl.scan && match_next && is_last;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && (32'(ctrl.position) == INDEX))
        begin
            pattern_reg <= ctrl.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.scan)
            begin
                match_reg <= ctrl.clear ? 1'b0 : match_next;
            end
            if (ctrl.advance)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    assign match = match_reg;
    assign hit   = hit_reg;

endmodule

@@ hdl/ssm_hit_tree.sv @@
module ssm_hit_tree
    import ssm_pkg::*;
#(
    parameter int LANES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [LANES-1:0] hits,
    output logic             any_hit
);

    localparam int GROUPS = (LANES + HIT_GROUP - 1) / HIT_GROUP;

    logic [GROUPS*HIT_GROUP-1:0] padded;
    logic [GROUPS-1:0]           group_reg;
    logic [GROUPS-1:0]           group_next;

    always_comb
    begin
        padded = '0;
        padded[LANES-1:0] = hits;
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = |padded[g*HIT_GROUP +: HIT_GROUP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
        end
        else if (advance)
        begin
            group_reg <= group_next;
        end
    end

    assign any_hit = |group_reg;

endmodule

@@ hdl/signature_substring_matcher.sv @@
// Signature substring matcher. Load words (op 0) write one signature byte at
// their position; scan words (op 1) stream buffer bytes through a row of
// PATTERN_MAX cells, each holding one signature byte and one partial-match bit
// handed on to its neighbor, so every alignment is checked per scan word. One
// word is accepted per clock unless the input stalls. A buffer's found flag
// reaches the result channel after its last scan word is accepted: the cell
// hit bits are registered, reduced through a registered OR tree, and folded
// into the output register. The input stalls only while a second buffer's
// flag is ready and the previous flag has not been taken. The signature
// store has no reset and needs no clearing pass; a scan against a byte never
// loaded is undefined. pattern_length lives at byte address 0 of the APB port.
module signature_substring_matcher
    import ssm_pkg::*;
#(
    parameter int PATTERN_MAX = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ssm_item_if.sink              item,
    ssm_result_if.source          result
);

    localparam int IDX_W = $clog2(PATTERN_MAX);

    logic [LEN_CFG_W-1:0] pattern_length_reg;
    logic [IDX_W-1:0]     last_idx;
    ssm_cell_ctrl_t       ctrl;
    logic                 advance;
    logic                 accept;
    logic [PATTERN_MAX-1:0] match_chain;
    logic [PATTERN_MAX-1:0] hit_vec;
    logic                 any_hit;

    logic s1_valid_reg, s1_last_reg;
    logic s2_valid_reg, s2_last_reg;
    logic seen_reg, seen_next;
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= PATTERN_LENGTH_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[PADDR_W-1:2] == REG_PATTERN_LENGTH))
        begin
            pattern_length_reg <= pwdata[LEN_CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_PATTERN_LENGTH)
        begin
            prdata = APB_DATA_W'(pattern_length_reg);
        end
    end

    // Index of the cell that completes a match; zero acts as length one.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(pattern_length_reg) >= PATTERN_MAX)
        begin
            last_idx = IDX_W'(PATTERN_MAX - 1);
        end
        else
        begin
            last_idx = IDX_W'(pattern_length_reg - LEN_CFG_W'(1));
        end
    end

    // Everything freezes only when a finished flag reaches the end while the
    // output register still holds the previous one.
    assign advance    = !(s2_valid_reg && s2_last_reg && out_valid_reg && !result.ready);
    assign item.ready = advance;
    assign accept     = item.valid && advance;

    always_comb
    begin
        ctrl.advance  = advance;
        ctrl.load     = accept && (item.op == OP_LOAD);
        ctrl.scan     = accept && (item.op == OP_SCAN);
        ctrl.clear    = item.last;
        ctrl.position = item.position;
        ctrl.value    = item.value;
    end

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic prev;
        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = match_chain[i-1];
        end
        ssm_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .last_idx   (last_idx),
            .prev_match (prev),
            .match      (match_chain[i]),
            .hit        (hit_vec[i])
        );
    end

    ssm_hit_tree #(
        .LANES (PATTERN_MAX)
    ) u_hit_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .hits    (hit_vec),
        .any_hit (any_hit)
    );

    always_comb
    begin
        seen_next      = seen_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (advance && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                out_found_next = seen_reg || any_hit;
                out_valid_next = 1'b1;
                seen_next      = 1'b0;
            end
            else
            begin
                seen_next = seen_reg || any_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= ctrl.scan;
                s1_last_reg  <= item.last;
                s2_valid_reg <= s1_valid_reg;
                s2_last_reg  <= s1_last_reg;
            end
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
    end

    assign result.valid = out_valid_reg;
    assign result.found = out_found_reg;

    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (out_valid_reg && s2_valid_reg && s2_last_reg))
        else $error("input stalled without a blocked result");

    a_result_from_buffer_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg && s2_last_reg) |=> out_valid_reg)
        else $error("ended buffer produced no result");

    a_new_result_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("result raised without an ended buffer");

    a_match_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.scan && item.last) |=> (match_chain == '0))
        else $error("partial matches not cleared after last word");

endmodule
